[sv/bda_pkg.sv]
package bda_pkg;

  localparam int NUMBER_W = 32;
  localparam int CHAR_W = 6;
  localparam int DEFAULT_MAX_DIGITS = 10;

  localparam logic [CHAR_W-1:0] CH_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CH_NINE = 6'd57;

  localparam int MODE_STRIP_BIT = 0;
  localparam int MODE_SIGNED_BIT = 1;

  localparam logic [1:0] SIZE_3 = 2'd0;
  localparam logic [1:0] SIZE_5 = 2'd1;

  // Reciprocal of ten: floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for 32-bit v.
  localparam logic [NUMBER_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  function automatic logic [3:0] digit_count(input logic [1:0] code);
    logic [3:0] n;
    case (code)
      SIZE_3:  n = 4'd3;
      SIZE_5:  n = 4'd5;
      default: n = 4'd10;
    endcase
    return n;
  endfunction

endpackage

[sv/bda_if.sv]
interface bda_in_if
  import bda_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [1:0]          size_code;
  logic [NUMBER_W-1:0] number;

  modport source (output valid, output mode, output size_code, output number, input ready);
  modport sink (input valid, input mode, input size_code, input number, output ready);
endinterface

interface bda_out_if
  import bda_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

[sv/binary_to_decimal_ascii.sv]
// Binary to decimal ASCII converter.
// The in_ch channel takes one beat holding a 32-bit number, a size code
// (3, 5 or 10 digits, capped at MAX_DIGITS) and a mode (unsigned or signed,
// padded or stripped). The out_ch channel sends the characters of that number,
// most significant digit first, with a leading '-' for negative signed input;
// last marks the final character of the run.
// After a beat is taken, the digits are found with one shared multiply by the
// reciprocal of ten, one digit per cycle. The characters then leave at one per
// cycle from an output register while the receiver is ready; a suppressed
// leading zero is dropped without sending a beat. in_ch.ready is high only
// while no conversion or emission is running; the next beat can be taken
// while the final character still waits in the output register. When the
// receiver stalls, the output register holds its beat and emission pauses.
// Synchronous reset returns the block to idle and drops any character not
// yet taken.
module binary_to_decimal_ascii
  import bda_pkg::*;
#(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input logic        clk,
  input logic        rst,
  bda_in_if.sink     in_ch,
  bda_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [3:0] MAX_N = 4'(MAX_DIGITS);

  state_t              state, state_next;
  logic [NUMBER_W-1:0] value, value_next;
  logic [3:0]          digs [MAX_DIGITS];
  logic [3:0]          digs_next [MAX_DIGITS];
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [CNT_W-1:0]    ndig, ndig_next;
  logic                sign_pending, sign_pending_next;
  logic                strip, strip_next;
  logic                ovalid, ovalid_next;
  logic [CHAR_W-1:0]   ochar, ochar_next;
  logic                olast, olast_next;

  logic [2*NUMBER_W-1:0] prod;
  logic [NUMBER_W-1:0]   quot;
  logic [NUMBER_W-1:0]   rem;
  logic [3:0]            n_code;
  logic [3:0]            n_sel;
  logic                  neg;
  logic                  can_load;
  logic [3:0]            top_dig;

  assign prod = {{NUMBER_W{1'b0}}, value} * {{NUMBER_W{1'b0}}, RECIP_10};
  assign quot = NUMBER_W'(prod[2*NUMBER_W-1:RECIP_SHIFT]);
  assign rem = value - ((quot << 3) + (quot << 1));

  assign n_code = digit_count(in_ch.size_code);
  assign n_sel = (n_code > MAX_N) ? MAX_N : n_code;
  assign neg = in_ch.mode[MODE_SIGNED_BIT] & in_ch.number[NUMBER_W-1];
  assign can_load = !ovalid || out_ch.ready;
  assign top_dig = digs[MAX_DIGITS-1];

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = ovalid;
  assign out_ch.out_char = ochar;
  assign out_ch.last = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      ovalid <= ovalid_next;
    end
    value <= value_next;
    digs <= digs_next;
    cnt <= cnt_next;
    ndig <= ndig_next;
    sign_pending <= sign_pending_next;
    strip <= strip_next;
    ochar <= ochar_next;
    olast <= olast_next;
  end

  always_comb begin
    state_next = state;
    value_next = value;
    digs_next = digs;
    cnt_next = cnt;
    ndig_next = ndig;
    sign_pending_next = sign_pending;
    strip_next = strip;
    ovalid_next = ovalid && !out_ch.ready;
    ochar_next = ochar;
    olast_next = olast;

    case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          value_next = neg ? (~in_ch.number + 1'b1) : in_ch.number;
          sign_pending_next = neg;
          strip_next = in_ch.mode[MODE_STRIP_BIT];
          cnt_next = CNT_W'(n_sel);
          ndig_next = CNT_W'(n_sel);
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        for (int i = 0; i < MAX_DIGITS - 1; i++) begin
          digs_next[i] = digs[i+1];
        end
        digs_next[MAX_DIGITS-1] = rem[3:0];
        value_next = quot;
        cnt_next = cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          if (sign_pending) begin
            sign_pending_next = 1'b0;
            ovalid_next = 1'b1;
            ochar_next = CH_MINUS;
            olast_next = 1'b0;
          end else begin
            for (int i = 1; i < MAX_DIGITS; i++) begin
              digs_next[i] = digs[i-1];
            end
            ndig_next = ndig - 1'b1;
            if (!(strip && top_dig == 4'd0 && ndig > CNT_W'(1))) begin
              strip_next = 1'b0;
              ovalid_next = 1'b1;
              ochar_next = CH_ZERO + CHAR_W'(top_dig);
              olast_next = (ndig == CNT_W'(1));
              if (ndig == CNT_W'(1)) begin
                state_next = ST_IDLE;
              end
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == ST_CONV))
    else $error("accepted beat did not start a conversion");

  a_conv_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> (cnt != '0))
    else $error("conversion running with no digits left");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.out_char == CH_MINUS) |-> !out_ch.last)
    else $error("minus sign marked as final character");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.out_char == CH_MINUS ||
                      (out_ch.out_char >= CH_ZERO && out_ch.out_char <= CH_NINE)))
    else $error("character outside the digit and sign set");

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !sign_pending && ndig == CNT_W'(0)) |-> 1'b0)
    else $error("emission running with no digits left");

endmodule

[tb/tb_binary_to_decimal_ascii.sv]
module tb_binary_to_decimal_ascii
  import bda_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_MAX_DIGITS = DEFAULT_MAX_DIGITS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 137;
  localparam int DRAIN_CYCLES = 30;

  localparam logic [1:0] MODE_UNSIGNED_PADDED = 2'd0;
  localparam logic [1:0] MODE_UNSIGNED_STRIPPED = 2'd1;
  localparam logic [1:0] MODE_SIGNED_PADDED = 2'd2;
  localparam logic [1:0] MODE_SIGNED_STRIPPED = 2'd3;

  localparam logic [1:0] SIZE_10 = 2'd2;
  localparam logic [1:0] SIZE_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } char_beat_t;

  logic clk;
  logic rst;

  bda_in_if in_ch ();
  bda_out_if out_ch ();

  binary_to_decimal_ascii #(
    .MAX_DIGITS(TB_MAX_DIGITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  char_beat_t expected_chars[$];
  int mismatch_count;
  int cycle_count;
  int stall_left;
  bit quiet;

  always #2 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int input_gap();
    if (quiet || $urandom_range(0, 99) < 60) begin
      return 0;
    end
    return pick_gap();
  endfunction

  // Expected characters for one beat, pushed in the order they leave the block.
  function automatic void predict_chars(input logic [1:0] mode, input logic [1:0] size_code,
                                        input logic [NUMBER_W-1:0] number);
    logic [3:0] digs [10];
    logic [NUMBER_W-1:0] mag;
    int ndig;
    int first;
    char_beat_t beat;
    case (size_code)
      SIZE_3:  ndig = 3;
      SIZE_5:  ndig = 5;
      default: ndig = 10;
    endcase
    if (ndig > TB_MAX_DIGITS) begin
      ndig = TB_MAX_DIGITS;
    end
    mag = number;
    if (mode[MODE_SIGNED_BIT] && number[NUMBER_W-1]) begin
      mag = '0 - number;
      beat.out_char = CH_MINUS;
      beat.last = 1'b0;
      expected_chars.push_back(beat);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      digs[i] = 4'(mag % 10);
      mag = mag / 10;
    end
    first = 0;
    if (mode[MODE_STRIP_BIT]) begin
      while (first + 1 < ndig && digs[first] == 4'd0) begin
        first++;
      end
    end
    for (int i = first; i < ndig; i++) begin
      beat.out_char = CH_ZERO + CHAR_W'(digs[i]);
      beat.last = (i == ndig - 1);
      expected_chars.push_back(beat);
    end
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s", what);
    end
  endtask

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_number(input logic [1:0] mode, input logic [1:0] size_code,
                             input logic [NUMBER_W-1:0] number);
    int gap;
    gap = input_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.size_code <= size_code;
    in_ch.number <= number;
    predict_chars(mode, size_code, number);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    char_beat_t exp_beat;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected beat: out_char=%0d last=%0b",
                                out_ch.out_char, out_ch.last));
      end else begin
        exp_beat = expected_chars.pop_front();
        if (out_ch.out_char !== exp_beat.out_char || out_ch.last !== exp_beat.last) begin
          note_mismatch($sformatf({"mismatch: expected out_char=%0d last=%0b, ",
                                   "got out_char=%0d last=%0b"},
                                  exp_beat.out_char, exp_beat.last,
                                  out_ch.out_char, out_ch.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_extremes();
    for (int m = 0; m < 4; m++) begin
      send_number(2'(m), SIZE_10, 32'h0000_0000);
      send_number(2'(m), SIZE_10, 32'hFFFF_FFFF);
    end
    send_number(MODE_SIGNED_PADDED, SIZE_10, 32'h8000_0000);
    send_number(MODE_SIGNED_STRIPPED, SIZE_10, 32'h8000_0000);
    send_number(MODE_SIGNED_STRIPPED, SIZE_3, 32'h8000_0000);
    send_number(MODE_UNSIGNED_PADDED, SIZE_10, 32'h7FFF_FFFF);
    send_number(MODE_SIGNED_PADDED, SIZE_10, 32'h7FFF_FFFF);
  endtask

  task automatic test_stripping();
    send_number(MODE_UNSIGNED_STRIPPED, SIZE_3, 32'd1000);
    send_number(MODE_SIGNED_STRIPPED, SIZE_3, -32'sd1000);
    send_number(MODE_SIGNED_STRIPPED, SIZE_5, -32'sd7);
    send_number(MODE_UNSIGNED_STRIPPED, SIZE_5, 32'd100000);
    send_number(MODE_UNSIGNED_STRIPPED, SIZE_5, 32'd12345);
    send_number(MODE_SIGNED_PADDED, SIZE_3, -32'sd5);
  endtask

  task automatic test_size_codes();
    send_number(MODE_UNSIGNED_PADDED, SIZE_3, 32'd999);
    send_number(MODE_UNSIGNED_PADDED, SIZE_5, 32'd99999);
    send_number(MODE_UNSIGNED_STRIPPED, SIZE_UNUSED, 32'd4000000123);
    send_number(MODE_SIGNED_STRIPPED, SIZE_UNUSED, 32'hFFFF_FFFE);
  endtask

  function automatic logic [NUMBER_W-1:0] pick_number();
    logic [NUMBER_W-1:0] pow10 [10];
    logic [NUMBER_W-1:0] p;
    pow10[0] = 32'd1;
    for (int k = 1; k < 10; k++) begin
      pow10[k] = pow10[k-1] * 10;
    end
    p = pow10[$urandom_range(0, 9)];
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 20000);
      2: return '0 - NUMBER_W'($urandom_range(1, 20000));
      3: return p * NUMBER_W'($urandom_range(0, 9));
      4: return p + NUMBER_W'($urandom_range(0, 2)) - 1;
      default: return 32'h8000_0000 + NUMBER_W'($urandom_range(0, 4)) - 2;
    endcase
  endfunction

  task automatic test_random_numbers();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i < 40);
      send_number(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_number());
    end
    quiet = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.size_code = '0;
    in_ch.number = '0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    stall_left = 0;
    quiet = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_stripping();
    test_size_codes();
    test_random_numbers();
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      note_mismatch($sformatf("%0d expected beats never arrived", expected_chars.size()));
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
